@@ sv/lidar_point_deskew_timestamper_unit_defines.svh @@
// Assertion macros shared by the point deskew timestamper RTL.
`ifndef LIDAR_POINT_DESKEW_TIMESTAMPER_UNIT_DEFINES_SVH
`define LIDAR_POINT_DESKEW_TIMESTAMPER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LPDT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LPDT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lpdt_pkg.sv @@
// Types, constants and the arctangent table of the point deskew timestamper.
package lpdt_pkg;

  localparam int NUM_RINGS    = 64;
  localparam int RING_W       = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int CORDIC_STEPS = 16;

  // CORDIC datapath widths (angle unit 2^-16 degree)
  localparam int CX_W = 34;
  localparam int CZ_W = 27;

  localparam int YAW_LIMIT  = 23040;
  localparam int FULL_TURN  = 46080;
  localparam int HALF_TURN_Z = 180 * 65536;

  // Register indexes
  localparam logic [1:0] REG_SENSOR_KIND = 2'd0;
  localparam logic [1:0] REG_FILTER_STEP = 2'd1;
  localparam logic [1:0] REG_TS_PRESENT  = 2'd2;
  localparam logic [1:0] REG_TIME_SCALE  = 2'd3;

  // Sensor kinds (2 and 3 share the absolute rule)
  localparam logic [1:0] KIND_SPIN = 2'd0;
  localparam logic [1:0] KIND_REL  = 2'd1;

  typedef struct packed {
    logic [31:0]        x_bits;
    logic [31:0]        y_bits;
    logic [31:0]        z_bits;
    logic [31:0]        intensity_bits;
    logic [5:0]         ring;
    logic signed [63:0] point_time;
    logic               frame_start;
  } point_t;

  typedef struct packed {
    logic [31:0]        out_x_bits;
    logic [31:0]        out_y_bits;
    logic [31:0]        out_z_bits;
    logic [31:0]        out_intensity_bits;
    logic signed [31:0] time_offset;
  } result_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_vec_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [CZ_W-1:0] atan_step(input int i);
    logic signed [CZ_W-1:0] v;
    case (i)
      0:  v = CZ_W'(2949120);
      1:  v = CZ_W'(1740967);
      2:  v = CZ_W'(919879);
      3:  v = CZ_W'(466945);
      4:  v = CZ_W'(234379);
      5:  v = CZ_W'(117304);
      6:  v = CZ_W'(58666);
      7:  v = CZ_W'(29335);
      8:  v = CZ_W'(14668);
      9:  v = CZ_W'(7334);
      10: v = CZ_W'(3667);
      11: v = CZ_W'(1833);
      12: v = CZ_W'(917);
      13: v = CZ_W'(458);
      14: v = CZ_W'(229);
      15: v = CZ_W'(115);
      16: v = CZ_W'(57);
      17: v = CZ_W'(29);
      18: v = CZ_W'(14);
      19: v = CZ_W'(7);
      20: v = CZ_W'(4);
      21: v = CZ_W'(2);
      22: v = CZ_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/lpdt_cordic.sv @@
// Pipelined vectoring CORDIC, one iteration per stage.
module lpdt_cordic
  import lpdt_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  cordic_vec_t vin,
  output cordic_vec_t vout
);

  cordic_vec_t stg [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    cordic_vec_t src;
    cordic_vec_t nxt;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;

    if (i == 0) begin : g_first
      assign src = vin;
    end else begin : g_rest
      assign src = stg[i-1];
    end

    // rotate toward y = 0
    always_comb begin
      xs = $signed(src.x) >>> i;
      ys = $signed(src.y) >>> i;
      if (src.y >= 0) begin
        nxt.x = src.x + ys;
        nxt.y = src.y - xs;
        nxt.z = src.z + atan_step(i);
      end else begin
        nxt.x = src.x - ys;
        nxt.y = src.y + xs;
        nxt.z = src.z - atan_step(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) stg[i] <= nxt;
    end
  end

  assign vout = stg[CORDIC_STEPS-1];

endmodule

@@ sv/lidar_point_deskew_timestamper_unit.sv @@
// Top level: lidar point filter and time offset unit.
// Usage:
//   Points enter on pt (pt_valid/pt_ready), one beat per point. Kept points
//   leave on res (res_valid/res_ready) with coordinates unchanged and a
//   Q20.12 millisecond time offset. Dropped points produce no beat.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
// Throughput: one point per cycle while pt_ready is high; the datapath is a
//   fixed pipeline of capture, alignment, partial-product, CORDIC, ring table
//   read/update and output register stages up to res_valid.
// Per-ring state (first yaw, last offset) sits in one 64-entry table with a
//   registered read; the write of the previous beat is forwarded.
// Reset: rst clears the registers to their defaults, the frame counter and
//   the ring seen bits; the table needs no clearing.
// Stall: a two-entry output stage (register plus skid) holds results; input
//   keeps being accepted while one result waits, and pt_ready drops only when
//   both entries are full. The whole pipeline then freezes.
`include "lidar_point_deskew_timestamper_unit_defines.svh"
module lidar_point_deskew_timestamper_unit
  import lpdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        pt_valid,
  output logic        pt_ready,
  input  point_t      pt,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  localparam int RECIP_SH = 38;
  localparam logic [63:0] RECIP = ((64'd1 << RECIP_SH) + 64'd360) / 64'd361;
  localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;

  typedef struct packed {
    logic [31:0]        x_bits;
    logic [31:0]        y_bits;
    logic [31:0]        z_bits;
    logic [31:0]        i_bits;
    logic [5:0]         ring;
    logic               fs;
    logic               emit;
    logic               yaw_mode;
    logic               zero;
    logic signed [31:0] toff;
  } meta_t;

  // config registers
  logic [1:0]  sensor_kind;
  logic [7:0]  filter_step;
  logic        timestamps_present;
  logic [31:0] scale_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_kind        <= KIND_SPIN;
      filter_step        <= 8'd1;
      timestamps_present <= 1'b1;
      scale_q16          <= 32'd65536000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_KIND: sensor_kind        <= cfg_data[1:0];
        REG_FILTER_STEP: filter_step        <= cfg_data[7:0];
        REG_TS_PRESENT:  timestamps_present <= cfg_data[0];
        REG_TIME_SCALE:  scale_q16          <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid;
  logic acc;

  assign en       = !skid_valid;
  assign pt_ready = en;
  assign acc      = pt_valid && en;

  // frame counter and frame base time
  logic [7:0]  frame_index;
  logic [63:0] frame_base_time;
  logic [7:0]  fi;
  logic [7:0]  step;
  logic [8:0]  fi_inc;
  logic [7:0]  fi_next;
  logic [63:0] base_eff;

  always_comb begin
    fi       = pt.frame_start ? 8'd0 : frame_index;
    step     = (filter_step == 8'd0) ? 8'd1 : filter_step;
    fi_inc   = {1'b0, fi} + 9'd1;
    fi_next  = (fi_inc >= {1'b0, step}) ? 8'd0 : fi_inc[7:0];
    base_eff = pt.frame_start ? pt.point_time : frame_base_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index     <= '0;
      frame_base_time <= '0;
    end else if (acc) begin
      frame_index     <= fi_next;
      frame_base_time <= base_eff;
    end
  end

  // stage 1: captured beat
  logic        p1_valid;
  point_t      p1_pt;
  logic        p1_keep;
  logic [63:0] p1_base;

  always_ff @(posedge clk) begin
    if (rst) p1_valid <= 1'b0;
    else if (en) p1_valid <= acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pt   <= pt;
      p1_keep <= (fi == 8'd0);
      p1_base <= base_eff;
    end
  end

  // stage 2: finiteness, time magnitude, mantissa alignment
  function automatic logic [7:0] exp_eff(input logic [31:0] b);
    return (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  endfunction

  function automatic logic signed [31:0] align_mant(input logic [31:0] b,
                                                   input logic [7:0] emax);
    logic [29:0] m;
    logic [7:0]  sh;
    logic [31:0] am;
    m  = {(b[30:23] != 8'd0), b[22:0], 6'd0};
    sh = emax - exp_eff(b);
    am = {2'b00, m >> sh};
    return b[31] ? -$signed(am) : $signed(am);
  endfunction

  logic        p2_finite;
  logic [7:0]  ex;
  logic [7:0]  ey;
  logic [7:0]  emax;
  logic [64:0] diff;
  logic        c_neg;
  logic [63:0] c_mag;

  always_comb begin
    p2_finite = (p1_pt.x_bits[30:23] != 8'hFF) && (p1_pt.y_bits[30:23] != 8'hFF)
             && (p1_pt.z_bits[30:23] != 8'hFF);
    ex   = exp_eff(p1_pt.x_bits);
    ey   = exp_eff(p1_pt.y_bits);
    emax = (ex > ey) ? ex : ey;
    diff = {p1_pt.point_time[63], p1_pt.point_time} - {p1_base[63], p1_base};
    if (sensor_kind[1]) begin
      c_neg = diff[64];
      c_mag = c_neg ? 64'(-diff) : diff[63:0];
    end else begin
      c_neg = p1_pt.point_time[63];
      c_mag = c_neg ? 64'(-p1_pt.point_time) : p1_pt.point_time;
    end
  end

  logic               p2_valid;
  meta_t              p2_meta;
  logic               p2_neg;
  logic [63:0]        p2_mag;
  logic [31:0]        p2_f;
  logic               p2_sh36;
  logic signed [31:0] p2_ax;
  logic signed [31:0] p2_ay;

  always_ff @(posedge clk) begin
    if (rst) p2_valid <= 1'b0;
    else if (en) p2_valid <= p1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_meta.x_bits   <= p1_pt.x_bits;
      p2_meta.y_bits   <= p1_pt.y_bits;
      p2_meta.z_bits   <= p1_pt.z_bits;
      p2_meta.i_bits   <= p1_pt.intensity_bits;
      p2_meta.ring     <= p1_pt.ring;
      p2_meta.fs       <= p1_pt.frame_start;
      p2_meta.emit     <= p1_keep && p2_finite;
      p2_meta.yaw_mode <= (sensor_kind == KIND_SPIN) && !timestamps_present;
      p2_meta.zero     <= 1'b0;
      p2_meta.toff     <= '0;
      p2_neg  <= c_neg;
      p2_mag  <= c_mag;
      p2_f    <= (sensor_kind == KIND_SPIN) ? scale_q16 : 32'd1000;
      p2_sh36 <= (sensor_kind == KIND_SPIN);
      p2_ax   <= align_mant(p1_pt.x_bits, emax);
      p2_ay   <= align_mant(p1_pt.y_bits, emax);
    end
  end

  // stage 3: partial products, CORDIC pre-rotation into the right half plane
  cordic_vec_t cin;
  meta_t       s0_meta_next;

  always_comb begin
    cin.x = CX_W'(p2_ax);
    cin.y = CX_W'(p2_ay);
    cin.z = '0;
    if (p2_ax < 0) begin
      cin.x = -CX_W'(p2_ax);
      cin.y = -CX_W'(p2_ay);
      cin.z = p2_meta.y_bits[31] ? -CZ_W'(HALF_TURN_Z) : CZ_W'(HALF_TURN_Z);
    end
    s0_meta_next      = p2_meta;
    s0_meta_next.zero = (p2_ax == 0) && (p2_ay == 0);
  end

  logic        s0_valid;
  meta_t       s0_meta;
  logic [63:0] s0_pa;
  logic [63:0] s0_pb;
  logic        s0_neg;
  logic        s0_sh36;
  cordic_vec_t s0_cin;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= p2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_meta <= s0_meta_next;
      s0_pa   <= 64'(p2_mag[63:32]) * 64'(p2_f);
      s0_pb   <= 64'(p2_mag[31:0]) * 64'(p2_f);
      s0_neg  <= p2_neg;
      s0_sh36 <= p2_sh36;
      s0_cin  <= cin;
    end
  end

  // combine partial products, shift, saturate
  logic [64:0]        sum36;
  logic [64:0]        r36;
  logic [44:0]        r20;
  logic [32:0]        mag33;
  logic signed [31:0] toff;
  meta_t              md_head_next;

  always_comb begin
    sum36 = {1'b0, s0_pa} + {33'd0, s0_pb[63:32]};
    r36   = sum36 >> 4;
    r20   = {1'b0, s0_pa[31:0], 12'd0} + {1'b0, s0_pb[63:20]};
    if (s0_sh36) begin
      mag33 = (r36 > 65'(MAG_CAP)) ? MAG_CAP : r36[32:0];
    end else if (s0_pa[63:32] != 32'd0) begin
      mag33 = MAG_CAP;
    end else begin
      mag33 = (r20 > 45'(MAG_CAP)) ? MAG_CAP : r20[32:0];
    end
    if (s0_neg) begin
      toff = (mag33 >= 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(mag33[31:0]);
    end else begin
      toff = (mag33 > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag33[31:0]);
    end
    md_head_next      = s0_meta;
    md_head_next.toff = toff;
  end

  // CORDIC pipeline with matching side-band delay line
  cordic_vec_t cout;

  lpdt_cordic u_cordic (
    .clk  (clk),
    .en   (en),
    .vin  (s0_cin),
    .vout (cout)
  );

  meta_t md [1:CORDIC_STEPS];
  logic  mv [1:CORDIC_STEPS];

  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_delay
    if (k == 1) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) mv[k] <= 1'b0;
        else if (en) mv[k] <= s0_valid;
      end
      always_ff @(posedge clk) begin
        if (en) md[k] <= md_head_next;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (rst) mv[k] <= 1'b0;
        else if (en) mv[k] <= mv[k-1];
      end
      always_ff @(posedge clk) begin
        if (en) md[k] <= md[k-1];
      end
    end
  end

  // yaw rounding and clamp
  logic signed [CZ_W-1:0] zr;
  logic signed [17:0]     yr;
  logic signed [15:0]     yaw_c;

  always_comb begin
    zr = cout.z + CZ_W'(256);
    yr = 18'(zr >>> 9);
    if (md[CORDIC_STEPS].zero) yaw_c = '0;
    else if (yr > 18'sd23040) yaw_c = 16'(YAW_LIMIT);
    else if (yr < -18'sd23040) yaw_c = -16'(YAW_LIMIT);
    else yaw_c = yr[15:0];
  end

  // ring table: {first_yaw, last_offset}
  logic [47:0]       ring_mem [NUM_RINGS];
  logic [47:0]       rd_data;
  logic              wr_en;
  logic [RING_W-1:0] wr_addr;
  logic [47:0]       wr_data;

  logic               y_valid;
  meta_t              y_meta;
  logic signed [15:0] y_yaw;

  always_ff @(posedge clk) begin
    if (rst) y_valid <= 1'b0;
    else if (en) y_valid <= mv[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_meta  <= md[CORDIC_STEPS];
      y_yaw   <= yaw_c;
      rd_data <= ring_mem[RING_W'(md[CORDIC_STEPS].ring)];
      if (wr_en) ring_mem[wr_addr] <= wr_data;
    end
  end

  // forwarding of the previous table write
  logic              lw_valid;
  logic [RING_W-1:0] lw_addr;
  logic [47:0]       lw_data;

  always_ff @(posedge clk) begin
    if (rst) lw_valid <= 1'b0;
    else if (en) lw_valid <= wr_en;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lw_addr <= wr_addr;
      lw_data <= wr_data;
    end
  end

  // ring update stage
  logic [NUM_RINGS-1:0] ring_seen;
  logic [NUM_RINGS-1:0] seen_eff;
  logic [NUM_RINGS-1:0] seen_set;
  logic [RING_W-1:0]    ring_a;
  logic                 ring_ok;
  logic                 seen;
  logic [47:0]          entry;
  logic signed [15:0]   first;
  logic signed [31:0]   last;
  logic signed [17:0]   d18;
  logic [16:0]          dd;
  logic [28:0]          n1;
  logic [28:0]          n2;
  logic [29:0]          q1;
  logic [29:0]          q2;
  logic [31:0]          yoff;
  logic                 yaw_item;
  logic                 emit;

  always_comb begin
    ring_a   = RING_W'(y_meta.ring);
    ring_ok  = int'(y_meta.ring) < NUM_RINGS;
    seen_eff = y_meta.fs ? '0 : ring_seen;
    seen     = seen_eff[ring_a];
    entry    = (lw_valid && (lw_addr == ring_a)) ? lw_data : rd_data;
    first    = $signed(entry[47:32]);
    last     = $signed(entry[31:0]);
    d18      = 18'(first) - 18'(y_yaw);
    if (y_yaw > first) d18 = d18 + 18'(FULL_TURN);
    dd   = d18[16:0];
    n1   = 29'(dd) * 29'd3200 + 29'd180;
    n2   = (29'(dd) + 29'(FULL_TURN)) * 29'd3200 + 29'd180;
    q1   = 30'((64'(n1) * RECIP) >> RECIP_SH);
    q2   = 30'((64'(n2) * RECIP) >> RECIP_SH);
    yoff = ($signed({2'b00, q1}) < last) ? {2'b00, q2} : {2'b00, q1};
    yaw_item = y_valid && y_meta.emit && y_meta.yaw_mode && ring_ok;
    wr_en    = en && yaw_item;
    wr_addr  = ring_a;
    wr_data  = seen ? {first, yoff} : {y_yaw, 32'd0};
    seen_set = '0;
    if (yaw_item && !seen) seen_set[ring_a] = 1'b1;
    emit = y_valid && y_meta.emit && (!y_meta.yaw_mode || (ring_ok && seen));
  end

  always_ff @(posedge clk) begin
    if (rst) ring_seen <= '0;
    else if (en && y_valid) ring_seen <= seen_eff | seen_set;
  end

  // output register plus skid entry
  result_t res_new;
  result_t skid;
  logic    push;
  logic    pop;

  always_comb begin
    res_new.out_x_bits         = y_meta.x_bits;
    res_new.out_y_bits         = y_meta.y_bits;
    res_new.out_z_bits         = y_meta.z_bits;
    res_new.out_intensity_bits = y_meta.i_bits;
    res_new.time_offset        = y_meta.yaw_mode ? $signed(yoff) : y_meta.toff;
    push = en && emit;
    pop  = res_valid && res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        res       <= res_new;
        res_valid <= 1'b1;
      end else begin
        skid       <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // checks
  `LPDT_CHECK(a_skid_behind_out, skid_valid, res_valid, "skid entry held without output beat")
  `LPDT_CHECK_NEXT(a_seen_frozen, !en, $stable(ring_seen), "ring seen bits moved during stall")
  `LPDT_CHECK(a_yaw_off_range, wr_en, wr_data[31:30] == 2'b00, "yaw offset out of range")

endmodule
